// File: sv/acpu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and microcode table of the accumulator CPU core.
package acpu_pkg;

  localparam int MemDepth = 256;
  localparam int AddrW    = $clog2(MemDepth);
  localparam int DataW    = 8;
  localparam int PcW      = AddrW + 1;

  localparam logic [3:0] OP_NOP = 4'h0;
  localparam logic [3:0] OP_STA = 4'h1;
  localparam logic [3:0] OP_LDA = 4'h2;
  localparam logic [3:0] OP_ADD = 4'h3;
  localparam logic [3:0] OP_OR  = 4'h4;
  localparam logic [3:0] OP_AND = 4'h5;
  localparam logic [3:0] OP_NOT = 4'h6;
  localparam logic [3:0] OP_JMP = 4'h8;
  localparam logic [3:0] OP_JN  = 4'h9;
  localparam logic [3:0] OP_JZ  = 4'hA;
  localparam logic [3:0] OP_HLT = 4'hF;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_EXEC,
    CMD_RESTART
  } cmd_t;

  typedef enum logic [4:0] {
    U_WRITE,
    U_READ,
    U_READ_OUT,
    U_RESTART,
    U_FETCH,
    U_OPERAND,
    U_DECODE,
    U_FINISH,
    U_NOP,
    U_STA,
    U_LDA,
    U_ADD,
    U_OR,
    U_AND,
    U_NOT,
    U_JMP,
    U_JN,
    U_JZ,
    U_HLT,
    U_UNKNOWN
  } upc_t;

  typedef enum logic [2:0] {
    ADDR_PC,
    ADDR_PC1,
    ADDR_RDATA,
    ADDR_ARG,
    ADDR_IN
  } addr_sel_t;

  typedef enum logic {
    WD_ACC,
    WD_IN
  } wsel_t;

  typedef enum logic [2:0] {
    ALU_PASS,
    ALU_LOAD,
    ALU_ADD,
    ALU_OR,
    ALU_AND,
    ALU_NOT
  } alu_t;

  typedef enum logic [2:0] {
    PC_HOLD,
    PC_INC1,
    PC_INC2,
    PC_ARG,
    PC_ARG_N,
    PC_ARG_Z,
    PC_HALT
  } pc_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_SKIP_STOPPED,
    SEQ_DISPATCH,
    SEQ_END
  } seq_t;

  typedef struct packed {
    addr_sel_t addr_sel;
    logic      mem_we;
    wsel_t     wsel;
    logic      ld_ir;
    logic      ld_arg;
    logic      ld_rdout;
    alu_t      alu_op;
    logic      upd_flags;
    pc_op_t    pc_op;
    logic      clr_regs;
    seq_t      seq;
    upc_t      target;
  } ctrl_t;

  typedef struct packed {
    logic       stopped;
    logic [3:0] opcode;
  } dp_status_t;

  localparam ctrl_t CTRL_IDLE = '{
    addr_sel: ADDR_PC, mem_we: 1'b0, wsel: WD_ACC, ld_ir: 1'b0, ld_arg: 1'b0,
    ld_rdout: 1'b0, alu_op: ALU_PASS, upd_flags: 1'b0, pc_op: PC_HOLD,
    clr_regs: 1'b0, seq: SEQ_NEXT, target: U_FINISH
  };

  function automatic upc_t entry(cmd_t cmd);
    upc_t u;
    unique case (cmd)
      CMD_WRITE: u = U_WRITE;
      CMD_READ:  u = U_READ;
      CMD_EXEC:  u = U_FETCH;
      default:   u = U_RESTART;
    endcase
    return u;
  endfunction

  function automatic upc_t dispatch(logic [3:0] op);
    upc_t u;
    unique case (op)
      OP_NOP:  u = U_NOP;
      OP_STA:  u = U_STA;
      OP_LDA:  u = U_LDA;
      OP_ADD:  u = U_ADD;
      OP_OR:   u = U_OR;
      OP_AND:  u = U_AND;
      OP_NOT:  u = U_NOT;
      OP_JMP:  u = U_JMP;
      OP_JN:   u = U_JN;
      OP_JZ:   u = U_JZ;
      OP_HLT:  u = U_HLT;
      default: u = U_UNKNOWN;
    endcase
    return u;
  endfunction

  function automatic ctrl_t ucode(upc_t u);
    ctrl_t c;
    c = CTRL_IDLE;
    c.seq = SEQ_END;
    unique case (u)
      U_WRITE: begin
        c.addr_sel = ADDR_IN;
        c.mem_we   = 1'b1;
        c.wsel     = WD_IN;
      end
      U_READ: begin
        c.addr_sel = ADDR_IN;
        c.seq      = SEQ_NEXT;
      end
      U_READ_OUT: c.ld_rdout = 1'b1;
      U_RESTART:  c.clr_regs = 1'b1;
      U_FETCH: begin
        c.addr_sel = ADDR_PC;
        c.seq      = SEQ_SKIP_STOPPED;
        c.target   = U_FINISH;
      end
      U_OPERAND: begin
        c.addr_sel = ADDR_PC1;
        c.ld_ir    = 1'b1;
        c.seq      = SEQ_NEXT;
      end
      U_DECODE: begin
        c.addr_sel = ADDR_RDATA;
        c.ld_arg   = 1'b1;
        c.seq      = SEQ_DISPATCH;
      end
      U_FINISH: c.seq = SEQ_END;
      U_NOP: begin
        c.upd_flags = 1'b1;
        c.pc_op     = PC_INC1;
      end
      U_STA: begin
        c.addr_sel  = ADDR_ARG;
        c.mem_we    = 1'b1;
        c.wsel      = WD_ACC;
        c.upd_flags = 1'b1;
        c.pc_op     = PC_INC2;
      end
      U_LDA: begin
        c.alu_op    = ALU_LOAD;
        c.upd_flags = 1'b1;
        c.pc_op     = PC_INC2;
      end
      U_ADD: begin
        c.alu_op    = ALU_ADD;
        c.upd_flags = 1'b1;
        c.pc_op     = PC_INC2;
      end
      U_OR: begin
        c.alu_op    = ALU_OR;
        c.upd_flags = 1'b1;
        c.pc_op     = PC_INC2;
      end
      U_AND: begin
        c.alu_op    = ALU_AND;
        c.upd_flags = 1'b1;
        c.pc_op     = PC_INC2;
      end
      U_NOT: begin
        c.alu_op    = ALU_NOT;
        c.upd_flags = 1'b1;
        c.pc_op     = PC_INC1;
      end
      U_JMP: begin
        c.upd_flags = 1'b1;
        c.pc_op     = PC_ARG;
      end
      U_JN: begin
        c.upd_flags = 1'b1;
        c.pc_op     = PC_ARG_N;
      end
      U_JZ: begin
        c.upd_flags = 1'b1;
        c.pc_op     = PC_ARG_Z;
      end
      U_HLT: c.pc_op = PC_HALT;
      default: begin
        c.upd_flags = 1'b1;
        c.pc_op     = PC_INC2;
      end
    endcase
    return c;
  endfunction

endpackage

// File: sv/acpu_mem.sv
`timescale 1ns / 1ps
// Single-port main memory with registered read and a clearing pass after reset.
module acpu_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [acpu_pkg::AddrW-1:0] addr,
  input  logic [acpu_pkg::DataW-1:0] wdata,
  output logic [acpu_pkg::DataW-1:0] rdata,
  output logic                       clearing
);
  import acpu_pkg::*;

  logic [DataW-1:0] mem [MemDepth];
  logic [AddrW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_cnt  <= clr_cnt + AddrW'(1);
      clearing <= (clr_cnt != AddrW'(MemDepth - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/acpu_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store and jump logic.
module acpu_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           operation,
  input  logic                 clearing,
  input  acpu_pkg::dp_status_t status,
  output acpu_pkg::ctrl_t      ctrl,
  output logic                 accept,
  output logic                 busy
);
  import acpu_pkg::*;

  logic running;
  upc_t upc;

  assign busy   = running | clearing;
  assign accept = start & ~busy;
  assign ctrl   = running ? ucode(upc) : CTRL_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      upc     <= U_FINISH;
    end else if (!running) begin
      if (accept) begin
        running <= 1'b1;
        upc     <= entry(cmd_t'(operation));
      end
    end else begin
      unique case (ctrl.seq)
        SEQ_NEXT:         upc <= upc_t'(upc + 5'd1);
        SEQ_SKIP_STOPPED: upc <= status.stopped ? ctrl.target : upc_t'(upc + 5'd1);
        SEQ_DISPATCH:     upc <= dispatch(status.opcode);
        default:          running <= 1'b0;
      endcase
    end
  end

endmodule

// File: sv/acpu_dp.sv
`timescale 1ns / 1ps
// Datapath: accumulator, program counter, flags, instruction registers and result registers.
module acpu_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  acpu_pkg::ctrl_t            ctrl,
  input  logic                       accept,
  input  logic [acpu_pkg::AddrW-1:0] in_addr,
  input  logic [acpu_pkg::DataW-1:0] in_wdata,
  input  logic [acpu_pkg::DataW-1:0] mem_rdata,
  output logic [acpu_pkg::AddrW-1:0] mem_addr,
  output logic [acpu_pkg::DataW-1:0] mem_wdata,
  output logic                       mem_we,
  output acpu_pkg::dp_status_t       status,
  output logic                       done,
  output logic [acpu_pkg::DataW-1:0] read_data,
  output logic [acpu_pkg::DataW-1:0] acc,
  output logic [acpu_pkg::PcW-1:0]   pc,
  output logic                       neg,
  output logic                       zero,
  output logic                       halt
);
  import acpu_pkg::*;

  logic [AddrW-1:0] addr_reg;
  logic [DataW-1:0] wdata_reg;
  logic [3:0]       ir;
  logic [AddrW-1:0] arg;
  logic [DataW-1:0] alu_out;
  logic [PcW-1:0]   pc_next;
  logic             halt_next;

  assign status.stopped = halt | pc[PcW-1];
  assign status.opcode  = ir;
  assign mem_we         = ctrl.mem_we;
  assign mem_wdata      = (ctrl.wsel == WD_IN) ? wdata_reg : acc;

  always_comb begin
    unique case (ctrl.addr_sel)
      ADDR_PC:    mem_addr = pc[AddrW-1:0];
      ADDR_PC1:   mem_addr = pc[AddrW-1:0] + AddrW'(1);
      ADDR_RDATA: mem_addr = mem_rdata[AddrW-1:0];
      ADDR_ARG:   mem_addr = arg;
      default:    mem_addr = addr_reg;
    endcase
  end

  always_comb begin
    unique case (ctrl.alu_op)
      ALU_LOAD: alu_out = mem_rdata;
      ALU_ADD:  alu_out = acc + mem_rdata;
      ALU_OR:   alu_out = acc | mem_rdata;
      ALU_AND:  alu_out = acc & mem_rdata;
      ALU_NOT:  alu_out = ~acc;
      default:  alu_out = acc;
    endcase
  end

  always_comb begin
    halt_next = halt;
    unique case (ctrl.pc_op)
      PC_INC1:  pc_next = pc + PcW'(1);
      PC_INC2:  pc_next = pc + PcW'(2);
      PC_ARG:   pc_next = {1'b0, arg};
      PC_ARG_N: pc_next = neg ? {1'b0, arg} : pc + PcW'(2);
      PC_ARG_Z: pc_next = zero ? {1'b0, arg} : pc + PcW'(2);
      PC_HALT: begin
        pc_next   = pc + PcW'(1);
        halt_next = 1'b1;
      end
      default:  pc_next = pc;
    endcase
    if (pc_next[PcW-1]) begin
      pc_next   = PcW'(MemDepth);
      halt_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      pc        <= '0;
      neg       <= 1'b0;
      zero      <= 1'b0;
      halt      <= 1'b0;
      done      <= 1'b0;
      read_data <= '0;
    end else begin
      done <= (ctrl.seq == SEQ_END);
      if (ctrl.seq == SEQ_END) begin
        read_data <= ctrl.ld_rdout ? mem_rdata : '0;
      end
      if (ctrl.clr_regs) begin
        acc  <= '0;
        pc   <= '0;
        neg  <= 1'b0;
        zero <= 1'b0;
        halt <= 1'b0;
      end else begin
        acc  <= alu_out;
        pc   <= pc_next;
        halt <= halt_next;
        if (ctrl.upd_flags) begin
          neg  <= alu_out[DataW-1];
          zero <= (alu_out == '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_reg  <= in_addr;
      wdata_reg <= in_wdata;
    end
    if (ctrl.ld_ir) begin
      ir <= mem_rdata[DataW-1:DataW-4];
    end
    if (ctrl.ld_arg) begin
      arg <= mem_rdata[AddrW-1:0];
    end
  end

endmodule

// File: sv/accumulator_cpu_core.sv
`timescale 1ns / 1ps
// Top level of the 8-bit accumulator CPU core with its 256-byte memory.
//
// An item is taken when start is high and busy is low. It carries an operation
// (write a memory byte, read a memory byte, execute one instruction, restart)
// together with mem_address and write_data. Exactly one result follows: done is
// high for one cycle with read_data, accumulator, program_counter, the flags and
// halted valid in that cycle. The receiver cannot hold results off.
// A microcoded sequencer steps a single-port memory and a plain datapath.
// A write or a restart ends in its own microstep, a read runs an address step
// and then an output step, an executed instruction the fetch, operand, decode and
// execute steps, and an execute while halted the fetch and finish steps. Busy
// falls in the cycle in which done is high, so a new item may be accepted then;
// an executed instruction's length is set by the opcode, operand and data
// accesses through the one memory port. After reset the memory is cleared one
// byte a cycle, with busy high until it is done; the CPU registers are cleared at once.
module accumulator_cpu_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 operation,
  input  logic [acpu_pkg::AddrW-1:0] mem_address,
  input  logic [acpu_pkg::DataW-1:0] write_data,
  output logic                       done,
  output logic [acpu_pkg::DataW-1:0] read_data,
  output logic [acpu_pkg::DataW-1:0] accumulator,
  output logic [acpu_pkg::PcW-1:0]   program_counter,
  output logic                       negative_flag,
  output logic                       zero_flag,
  output logic                       halted
);
  import acpu_pkg::*;

  ctrl_t            ctrl;
  dp_status_t       status;
  logic             accept;
  logic             clearing;
  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [DataW-1:0] mem_wdata;
  logic [DataW-1:0] mem_rdata;

  acpu_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .we       (mem_we),
    .addr     (mem_addr),
    .wdata    (mem_wdata),
    .rdata    (mem_rdata),
    .clearing (clearing)
  );

  acpu_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .clearing  (clearing),
    .status    (status),
    .ctrl      (ctrl),
    .accept    (accept),
    .busy      (busy)
  );

  acpu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .accept    (accept),
    .in_addr   (mem_address),
    .in_wdata  (write_data),
    .mem_rdata (mem_rdata),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_we    (mem_we),
    .status    (status),
    .done      (done),
    .read_data (read_data),
    .acc       (accumulator),
    .pc        (program_counter),
    .neg       (negative_flag),
    .zero      (zero_flag),
    .halt      (halted)
  );

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("busy not raised after an item was taken");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  a_pc_end_halts: assert property (@(posedge clk) disable iff (rst)
    program_counter[PcW-1] |-> halted)
    else $error("program counter past the end without halt");

endmodule

// File: tb/accumulator_cpu_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the accumulator CPU core: directed and program-based random items.
module accumulator_cpu_core_test;
  import acpu_pkg::*;

  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] acc;
    logic [8:0] pc;
    logic       neg;
    logic       zf;
    logic       halt;
  } cpu_view_t;

  class cpu_mirror;
    logic [7:0] mem [256];
    logic [7:0] acc;
    logic [8:0] pc;
    logic       neg;
    logic       zf;
    logic       halt;
    cpu_view_t  due_states[$];
    int         errors;
    int         shown;

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      acc    = 8'h00;
      pc     = 9'd0;
      neg    = 1'b0;
      zf     = 1'b0;
      halt   = 1'b0;
      errors = 0;
      shown  = 0;
    endfunction

    function void note_item(cmd_t op, logic [7:0] addr, logic [7:0] wdata);
      cpu_view_t  v;
      logic [3:0] opc;
      logic [7:0] opnd_at;
      logic [7:0] arg;
      logic [8:0] nxt;
      v.rdata = 8'h00;
      case (op)
        CMD_WRITE: mem[addr] = wdata;
        CMD_READ:  v.rdata = mem[addr];
        CMD_EXEC: begin
          if (!halt && !pc[8]) begin
            opc     = mem[pc[7:0]][7:4];
            opnd_at = pc[7:0] + 8'd1;
            arg     = mem[opnd_at];
            if (opc == OP_HLT) begin
              pc   = pc + 9'd1;
              halt = 1'b1;
            end else begin
              nxt = (opc == OP_NOP || opc == OP_NOT) ? pc + 9'd1 : pc + 9'd2;
              case (opc)
                OP_STA: mem[arg] = acc;
                OP_LDA: acc = mem[arg];
                OP_ADD: acc = acc + mem[arg];
                OP_OR:  acc = acc | mem[arg];
                OP_AND: acc = acc & mem[arg];
                OP_NOT: acc = ~acc;
                OP_JMP: nxt = {1'b0, arg};
                OP_JN:  if (neg) nxt = {1'b0, arg};
                OP_JZ:  if (zf) nxt = {1'b0, arg};
                default: ;
              endcase
              neg = acc[7];
              zf  = (acc == 8'h00);
              if (nxt > 9'd255) begin
                nxt  = 9'd256;
                halt = 1'b1;
              end
              pc = nxt;
            end
          end
        end
        default: begin
          acc  = 8'h00;
          pc   = 9'd0;
          neg  = 1'b0;
          zf   = 1'b0;
          halt = 1'b0;
        end
      endcase
      v.acc  = acc;
      v.pc   = pc;
      v.neg  = neg;
      v.zf   = zf;
      v.halt = halt;
      due_states.push_back(v);
    endfunction

    function void check_result(cpu_view_t got);
      cpu_view_t want;
      if (due_states.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: rd=%h ac=%h pc=%h n=%b z=%b h=%b",
                   got.rdata, got.acc, got.pc, got.neg, got.zf, got.halt);
        end
      end else begin
        want = due_states.pop_front();
        if (got !== want) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: expected rd=%h ac=%h pc=%h n=%b z=%b h=%b",
                     want.rdata, want.acc, want.pc, want.neg, want.zf, want.halt);
            $display("          actual   rd=%h ac=%h pc=%h n=%b z=%b h=%b",
                     got.rdata, got.acc, got.pc, got.neg, got.zf, got.halt);
          end
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] operation = 2'd0;
  logic [7:0] mem_address = 8'h00;
  logic [7:0] write_data = 8'h00;
  logic       done;
  logic [7:0] read_data;
  logic [7:0] accumulator;
  logic [8:0] program_counter;
  logic       negative_flag;
  logic       zero_flag;
  logic       halted;

  cpu_mirror mirror = new();
  cpu_view_t seen;
  int        idle_pct = 13;
  int        sent = 0;

  accumulator_cpu_core dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .mem_address     (mem_address),
    .write_data      (write_data),
    .done            (done),
    .read_data       (read_data),
    .accumulator     (accumulator),
    .program_counter (program_counter),
    .negative_flag   (negative_flag),
    .zero_flag       (zero_flag),
    .halted          (halted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      seen = {read_data, accumulator, program_counter, negative_flag, zero_flag, halted};
      mirror.check_result(seen);
    end
  end

  task automatic issue(cmd_t op, logic [7:0] addr, logic [7:0] wdata);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    operation   <= op;
    mem_address <= addr;
    write_data  <= wdata;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.note_item(op, addr, wdata);
    sent++;
  endtask

  task automatic run_program();
    logic [7:0] base;
    logic [7:0] at;
    logic [7:0] opnd;
    logic [3:0] opc;
    int         len;
    int         steps;
    base = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255));
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(4))
        0: opnd = 8'h00;
        1: opnd = 8'h80;
        2: opnd = 8'hFF;
        3: opnd = 8'h7F;
        default: opnd = 8'($urandom);
      endcase
      issue(CMD_WRITE, 8'hC0 + 8'(i), opnd);
    end
    issue(CMD_RESTART, 8'($urandom), 8'($urandom));
    if (base != 8'h00) begin
      issue(CMD_WRITE, 8'h00, {OP_JMP, 4'($urandom)});
      issue(CMD_WRITE, 8'h01, base);
    end
    at  = base;
    len = $urandom_range(3, 10);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(11))
        0: opc = OP_NOP;
        1: opc = OP_STA;
        2: opc = OP_LDA;
        3: opc = OP_ADD;
        4: opc = OP_OR;
        5: opc = OP_AND;
        6: opc = OP_NOT;
        7: opc = OP_JMP;
        8: opc = OP_JN;
        9: opc = OP_JZ;
        default: opc = 4'($urandom);
      endcase
      issue(CMD_WRITE, at, {opc, 4'($urandom)});
      at = at + 8'd1;
      if (opc != OP_NOP && opc != OP_NOT && opc != OP_HLT) begin
        if (opc == OP_JMP || opc == OP_JN || opc == OP_JZ)
          opnd = base + 8'($urandom_range(0, 2 * len));
        else if ($urandom_range(4) == 0)
          opnd = 8'($urandom);
        else
          opnd = 8'hC0 + 8'($urandom_range(3));
        issue(CMD_WRITE, at, opnd);
        at = at + 8'd1;
      end
    end
    steps = $urandom_range(2, 3 * len);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(9) == 0)
        issue(CMD_READ, ($urandom_range(1) == 0) ? 8'hC0 + 8'($urandom_range(3))
                                                 : 8'($urandom), 8'($urandom));
      issue(CMD_EXEC, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int target;
    int waited;
    int burst;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    issue(CMD_READ, 8'h00, 8'hFF);
    issue(CMD_WRITE, 8'hFF, 8'hFF);
    issue(CMD_READ, 8'hFF, 8'h00);
    issue(CMD_EXEC, 8'h00, 8'h00);
    issue(CMD_WRITE, 8'h01, {OP_NOT, 4'hA});
    issue(CMD_EXEC, 8'h00, 8'h00);
    issue(CMD_WRITE, 8'h02, {OP_JN, 4'hF});
    issue(CMD_WRITE, 8'h03, 8'hFE);
    issue(CMD_EXEC, 8'hFF, 8'hFF);
    // The add at the last-but-one byte runs the program counter off the end.
    issue(CMD_WRITE, 8'hFE, {OP_ADD, 4'h0});
    issue(CMD_EXEC, 8'h00, 8'h00);
    issue(CMD_EXEC, 8'h00, 8'h00);
    issue(CMD_RESTART, 8'hA5, 8'h5A);
    issue(CMD_WRITE, 8'h00, {OP_JMP, 4'h5});
    issue(CMD_WRITE, 8'h01, 8'hFF);
    issue(CMD_EXEC, 8'h00, 8'h00);
    // A load at the last byte takes its operand address from byte zero.
    issue(CMD_WRITE, 8'hFF, {OP_LDA, 4'hC});
    issue(CMD_WRITE, 8'h85, 8'h01);
    issue(CMD_EXEC, 8'h00, 8'h00);
    issue(CMD_EXEC, 8'h00, 8'h00);
    issue(CMD_RESTART, 8'h00, 8'h00);
    issue(CMD_WRITE, 8'h00, {OP_HLT, 4'h3});
    issue(CMD_EXEC, 8'h00, 8'h00);
    issue(CMD_EXEC, 8'h00, 8'h00);
    issue(CMD_WRITE, 8'h00, {4'hB, 4'h1});
    issue(CMD_RESTART, 8'hFF, 8'hFF);
    issue(CMD_EXEC, 8'h00, 8'h00);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 13 : (phase == 1) ? 76 : 0;
      target   = sent + 367;
      while (sent < target) begin
        if ($urandom_range(99) < 85) begin
          run_program();
        end else begin
          burst = $urandom_range(1, 5);
          for (int i = 0; i < burst; i++)
            issue(cmd_t'($urandom_range(3)), 8'($urandom), 8'($urandom));
        end
      end
    end

    start  <= 1'b0;
    waited = 0;
    while (mirror.due_states.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    mirror.errors += mirror.due_states.size();
    if (mirror.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
